// File: src/pvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvc_pkg: shared types and constants for the plane volume classifier
// Fixed-point format, accumulator width, register indexes and result codes.
// ----------------------------------------------------------------------------
package pvc_pkg;

	// Fraction bits of the Q format used by all coordinates.
	localparam int FRAC_BITS = 16;

	// Coordinate and product widths.
	localparam int COORD_W = 32;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int RAD_W   = 31;

	// Three products plus the offset and radius terms are held in 67 bits signed.
	localparam int ACC_W = PROD_W + 3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_OFFSET = 2'd3;

	// Test selection.
	localparam logic MODE_BOX    = 1'b0;
	localparam logic MODE_SPHERE = 1'b1;

	typedef enum logic [1:0] {
		SIDE_FRONT = 2'd0,
		SIDE_BACK  = 2'd1,
		SIDE_ISECT = 2'd2
	} side_t;

	// Plane held in configuration.
	typedef struct packed {
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] nz;
		logic signed [COORD_W-1:0] off;
	} plane_t;

endpackage
`default_nettype wire

// File: src/pvc_dot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pvc_dot: pipelined plane evaluation n.p + d
// Multiplies in the first stage, pairwise adds in the second, final add in
// the third. The result carries 2*FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module pvc_dot (
	input  wire                                     clk,
	input  wire pvc_pkg::plane_t                    plane,
	input  wire logic signed [pvc_pkg::COORD_W-1:0] px,
	input  wire logic signed [pvc_pkg::COORD_W-1:0] py,
	input  wire logic signed [pvc_pkg::COORD_W-1:0] pz,
	output logic signed [pvc_pkg::ACC_W-1:0]        sum_s4
);

	localparam int OFF_W = pvc_pkg::COORD_W + pvc_pkg::FRAC_BITS;

	logic signed [pvc_pkg::PROD_W-1:0] prod_x_s2;
	logic signed [pvc_pkg::PROD_W-1:0] prod_y_s2;
	logic signed [pvc_pkg::PROD_W-1:0] prod_z_s2;
	logic signed [pvc_pkg::ACC_W-1:0]  sum_a_s3;
	logic signed [pvc_pkg::ACC_W-1:0]  sum_b_s3;
	logic signed [OFF_W-1:0]           off_term;

	// Offset scaled up to the product format.
	assign off_term = $signed({plane.off, {pvc_pkg::FRAC_BITS{1'b0}}});

	always_ff @(posedge clk) begin
		prod_x_s2 <= plane.nx * px;
		prod_y_s2 <= plane.ny * py;
		prod_z_s2 <= plane.nz * pz;
		sum_a_s3  <= pvc_pkg::ACC_W'(prod_x_s2) + pvc_pkg::ACC_W'(prod_y_s2);
		sum_b_s3  <= pvc_pkg::ACC_W'(prod_z_s2) + pvc_pkg::ACC_W'(off_term);
		sum_s4    <= sum_a_s3 + sum_b_s3;
	end

endmodule
`default_nettype wire

// File: src/plane_volume_classifier_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plane_volume_classifier_unit: box and sphere classification against a plane
// Culling test of one bounding volume per cycle against a configured plane.
// ----------------------------------------------------------------------------
// Usage:
// The plane (normal_x, normal_y, normal_z, plane_offset, all signed Q16.16)
// is loaded through the configuration channel: a word is written when
// cfg_valid and cfg_ready are both high, cfg_index selecting the register.
// cfg_ready is always high. Write the plane only while no test is in flight.
// A test word is accepted at a rising edge with start high and busy low.
// busy never rises, so a new word may be issued in every cycle.
// mode selects a box test (lo/hi corners) or a sphere test (lo centre and
// radius). Once the word has passed all stages, done is high for
// exactly one cycle while side and distance carry the result, and it must be
// taken in that cycle since the receiver cannot hold it off.
// Throughput is one word per cycle. Each word passes through the
// operand select stage, the three stages of the plane evaluation (multiply,
// pairwise add, final add) and the compare and saturate stage at the output.
// In box mode two evaluations run in parallel, one on the nearest corner and
// one on the farthest; in sphere mode only the first one is used.
// Reset clears the plane registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module plane_volume_classifier_unit (
	input  wire                                     clk,
	input  wire                                     arst_n,
	// Configuration channel.
	input  wire                                     cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pvc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pvc_pkg::COORD_W-1:0]        cfg_data,
	// Test words.
	input  wire                                     start,
	output logic                                    busy,
	input  wire                                     mode,
	input  wire logic signed [pvc_pkg::COORD_W-1:0] lo_x,
	input  wire logic signed [pvc_pkg::COORD_W-1:0] lo_y,
	input  wire logic signed [pvc_pkg::COORD_W-1:0] lo_z,
	input  wire logic signed [pvc_pkg::COORD_W-1:0] hi_x,
	input  wire logic signed [pvc_pkg::COORD_W-1:0] hi_y,
	input  wire logic signed [pvc_pkg::COORD_W-1:0] hi_z,
	input  wire logic [pvc_pkg::RAD_W-1:0]          radius,
	// Results.
	output logic                                    done,
	output logic [1:0]                              side,
	output logic signed [pvc_pkg::COORD_W-1:0]      distance
);

	localparam int ACC_W  = pvc_pkg::ACC_W;
	localparam int FRAC   = pvc_pkg::FRAC_BITS;
	localparam int CW     = pvc_pkg::COORD_W;
	localparam int RAD_W  = pvc_pkg::RAD_W;

	pvc_pkg::plane_t plane_q;

	logic                          accept;
	logic                          v_s1, v_s2, v_s3, v_s4;
	logic                          mode_s1, mode_s2, mode_s3, mode_s4;
	logic [RAD_W-1:0]              rad_s1, rad_s2, rad_s3, rad_s4;
	logic signed [CW-1:0]          near_x_s1, near_y_s1, near_z_s1;
	logic signed [CW-1:0]          far_x_s1, far_y_s1, far_z_s1;
	logic signed [ACC_W-1:0]       near_s4, far_s4;

	logic signed [ACC_W-1:0]       rad_wide;
	logic signed [ACC_W-1:0]       near_shift;
	logic                          dist_fits;
	logic signed [CW-1:0]          dist_sat;
	pvc_pkg::side_t                side_d;
	logic signed [CW-1:0]          dist_d;

	logic                          done_q;
	pvc_pkg::side_t                side_q;
	logic signed [CW-1:0]          dist_q;
	logic                          mode_o_q;

	// The pipeline never stalls, so both channels are always open.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Plane registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pvc_pkg::CFG_NORMAL_X:     plane_q.nx  <= cfg_data;
				pvc_pkg::CFG_NORMAL_Y:     plane_q.ny  <= cfg_data;
				pvc_pkg::CFG_NORMAL_Z:     plane_q.nz  <= cfg_data;
				pvc_pkg::CFG_PLANE_OFFSET: plane_q.off <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	// Stage 1: corner selection. A non-negative normal component takes the
	// minimum for the nearest corner and the maximum for the farthest. In
	// sphere mode the nearest evaluation runs on the centre.
	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		rad_s1  <= radius;
		if (mode == pvc_pkg::MODE_SPHERE) begin
			near_x_s1 <= lo_x;
			near_y_s1 <= lo_y;
			near_z_s1 <= lo_z;
		end else begin
			near_x_s1 <= plane_q.nx[CW-1] ? hi_x : lo_x;
			near_y_s1 <= plane_q.ny[CW-1] ? hi_y : lo_y;
			near_z_s1 <= plane_q.nz[CW-1] ? hi_z : lo_z;
		end
		far_x_s1 <= plane_q.nx[CW-1] ? lo_x : hi_x;
		far_y_s1 <= plane_q.ny[CW-1] ? lo_y : hi_y;
		far_z_s1 <= plane_q.nz[CW-1] ? lo_z : hi_z;
		mode_s2  <= mode_s1;
		rad_s2   <= rad_s1;
		mode_s3  <= mode_s2;
		rad_s3   <= rad_s2;
		mode_s4  <= mode_s3;
		rad_s4   <= rad_s3;
	end

	// Stages 2 to 4: plane evaluation of both corners.
	pvc_dot u_near (
		.clk    (clk),
		.plane  (plane_q),
		.px     (near_x_s1),
		.py     (near_y_s1),
		.pz     (near_z_s1),
		.sum_s4 (near_s4)
	);

	pvc_dot u_far (
		.clk    (clk),
		.plane  (plane_q),
		.px     (far_x_s1),
		.py     (far_y_s1),
		.pz     (far_z_s1),
		.sum_s4 (far_s4)
	);

	// Stage 5: classification and distance saturation.
	// The radius is scaled into the product format; the sphere is in front
	// when the centre value exceeds it and behind when it lies below its
	// negation. Values exactly on a bound count as intersecting.
	assign rad_wide   = $signed({{(ACC_W - RAD_W - FRAC){1'b0}}, rad_s4, {FRAC{1'b0}}});
	// Arithmetic shift rounds toward minus infinity.
	assign near_shift = near_s4 >>> FRAC;
	assign dist_fits  = (&near_shift[ACC_W-1:CW-1]) || !(|near_shift[ACC_W-1:CW-1]);
	assign dist_sat   = dist_fits ? near_shift[CW-1:0]
	                  : (near_s4[ACC_W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});

	always_comb begin
		side_d = pvc_pkg::SIDE_ISECT;
		dist_d = '0;
		if (mode_s4 == pvc_pkg::MODE_SPHERE) begin
			if (near_s4 > rad_wide) begin
				side_d = pvc_pkg::SIDE_FRONT;
			end else if (near_s4 < -rad_wide) begin
				side_d = pvc_pkg::SIDE_BACK;
			end
			dist_d = dist_sat;
		end else begin
			// The front test wins over the back test.
			if (near_s4 > 0) begin
				side_d = pvc_pkg::SIDE_FRONT;
			end else if (far_s4 < 0) begin
				side_d = pvc_pkg::SIDE_BACK;
			end
		end
	end

	always_ff @(posedge clk) begin
		side_q   <= side_d;
		dist_q   <= dist_d;
		mode_o_q <= mode_s4;
	end

	assign done     = done_q;
	assign side     = side_q;
	assign distance = dist_q;

	// Every word leaving the last evaluation stage is presented next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |=> done)
		else $error("result strobe missing after a valid final stage");

	// No strobe without a word in the last evaluation stage.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |=> !done)
		else $error("result strobe without a word in flight");

	// Box results carry no distance.
	a_box_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mode_o_q == pvc_pkg::MODE_BOX) |-> (distance == '0))
		else $error("nonzero distance on a box result");

	// A sphere in front has a non-negative centre distance.
	a_front_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mode_o_q == pvc_pkg::MODE_SPHERE && side == pvc_pkg::SIDE_FRONT)
		|-> !distance[CW-1])
		else $error("sphere in front with a negative distance");

endmodule
`default_nettype wire
